// ----- design/nnf_pkg.sv -----
// Package for the note-name-to-frequency decoder.
// Holds the parse phase type, the parse result struct and the frequency table.
// No dependencies.
package nnf_pkg;

    // Default number of fraction bits on the frequency output.
    localparam int FRAC_BITS_DEF = 16;

    localparam int FREQ_W = 31;
    localparam int NOTE_W = 9;
    localparam int PROD_W = 40;

    typedef enum logic [2:0] {
        PH_START,
        PH_LETTER,
        PH_ACC,
        PH_MINUS,
        PH_DIGITS,
        PH_DONE,
        PH_INVALID
    } t_phase;

    // Name as parsed up to and including the current character.
    typedef struct packed {
        logic       name_valid; // first character was a note letter
        logic [3:0] oct1;       // octave + 1, 0..10
        logic [4:0] acc;        // semitone above C plus 1, 0..13
    } t_parse_res;

    // Semitone above C of letters A..G.
    function automatic logic [3:0] letter_semi(input logic [2:0] idx);
        logic [3:0] v;
        case (idx)
            3'd0: v = 4'd9;
            3'd1: v = 4'd11;
            3'd2: v = 4'd0;
            3'd3: v = 4'd2;
            3'd4: v = 4'd4;
            3'd5: v = 4'd5;
            3'd6: v = 4'd7;
            default: v = 4'd0;
        endcase
        return v;
    endfunction

    // 440 * 2^(r/12) with the ratio in Q2.30, rounded to nearest; exact product.
    function automatic logic [PROD_W-1:0] note_prod(input logic [3:0] r);
        logic [PROD_W-1:0] v;
        case (r)
            4'd0:  v = 40'd472446402560;
            4'd1:  v = 40'd500539527400;
            4'd2:  v = 40'd530303156680;
            4'd3:  v = 40'd561836623480;
            4'd4:  v = 40'd595245167440;
            4'd5:  v = 40'd630640287200;
            4'd6:  v = 40'd668140110000;
            4'd7:  v = 40'd707869788560;
            4'd8:  v = 40'd749961916440;
            4'd9:  v = 40'd794556972440;
            4'd10: v = 40'd841803788760;
            4'd11: v = 40'd891860046880;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- design/nnf_parse.sv -----
// Character parser of the note-name decoder: phase, accidental and octave state.
// Depends on nnf_pkg (t_phase, t_parse_res, letter_semi).
module nnf_parse
    import nnf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic [7:0] i_char_code,
    input  logic       i_last_char,
    output t_parse_res o_res
);

    localparam logic [7:0] CH_SHARP = 8'd35;  // '#'
    localparam logic [7:0] CH_MINUS = 8'd45;  // '-'
    localparam logic [7:0] CH_ZERO  = 8'd48;  // '0'
    localparam logic [7:0] CH_NINE  = 8'd57;  // '9'
    localparam logic [7:0] CH_UA    = 8'd65;  // 'A'
    localparam logic [7:0] CH_UG    = 8'd71;  // 'G'
    localparam logic [7:0] CH_UF    = 8'd70;  // 'F'
    localparam logic [7:0] CH_US    = 8'd83;  // 'S'
    localparam logic [7:0] CH_LA    = 8'd97;  // 'a'
    localparam logic [7:0] CH_LB    = 8'd98;  // 'b'
    localparam logic [7:0] CH_LF    = 8'd102; // 'f'
    localparam logic [7:0] CH_LS    = 8'd115; // 's'
    localparam logic [7:0] CH_LZ    = 8'd122; // 'z'
    localparam logic [7:0] CASE_OFS = 8'd32;

    t_phase     r_phase, n_phase;
    logic [4:0] r_acc, n_acc;
    logic [3:0] r_mag, n_mag;
    logic       r_neg, n_neg;
    logic       r_dig, n_dig;

    logic [7:0] w_upper;
    logic [2:0] w_letter_ofs;
    logic       w_is_letter;
    logic       w_is_digit;
    logic       w_is_sharp;
    logic       w_is_flat;
    logic [3:0] w_digit;
    logic [3:0] w_mag_dig;

    always_comb begin
        w_upper      = (i_char_code >= CH_LA && i_char_code <= CH_LZ) ?
                       i_char_code - CASE_OFS : i_char_code;
        w_is_letter  = (w_upper >= CH_UA) && (w_upper <= CH_UG);
        w_letter_ofs = 3'(w_upper - CH_UA);
        w_is_digit   = (i_char_code >= CH_ZERO) && (i_char_code <= CH_NINE);
        w_is_sharp   = (i_char_code == CH_SHARP) || (i_char_code == CH_LS) ||
                       (i_char_code == CH_US);
        w_is_flat    = (i_char_code == CH_LB) || (i_char_code == CH_LF) ||
                       (i_char_code == CH_UF);
        w_digit      = 4'(i_char_code - CH_ZERO);
        // Any nonzero magnitude times ten already passes nine: saturate to ten.
        w_mag_dig    = (r_mag != 4'd0) ? 4'd10 : w_digit;
    end

    always_comb begin
        n_phase = r_phase;
        n_acc   = r_acc;
        n_mag   = r_mag;
        n_neg   = r_neg;
        n_dig   = r_dig;
        case (r_phase)
            PH_START: begin
                if (w_is_letter) begin
                    n_acc   = {1'b0, letter_semi(w_letter_ofs)} + 5'd1;
                    n_phase = PH_LETTER;
                end else begin
                    n_phase = PH_INVALID;
                end
            end
            PH_LETTER, PH_ACC: begin
                if (r_phase == PH_LETTER && w_is_sharp) begin
                    n_acc   = r_acc + 5'd1;
                    n_phase = PH_ACC;
                end else if (r_phase == PH_LETTER && w_is_flat) begin
                    n_acc   = r_acc - 5'd1;
                    n_phase = PH_ACC;
                end else if (i_char_code == CH_MINUS) begin
                    n_neg   = 1'b1;
                    n_phase = PH_MINUS;
                end else if (w_is_digit) begin
                    n_mag   = w_mag_dig;
                    n_dig   = 1'b1;
                    n_phase = PH_DIGITS;
                end else begin
                    n_phase = PH_DONE;
                end
            end
            PH_MINUS, PH_DIGITS: begin
                if (w_is_digit) begin
                    n_mag   = w_mag_dig;
                    n_dig   = 1'b1;
                    n_phase = PH_DIGITS;
                end else begin
                    n_phase = PH_DONE;
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
    end

    // Octave + 1: default octave four, any negative octave clamps to -1 ("-0" is 0).
    always_comb begin
        o_res.name_valid = (n_phase != PH_INVALID) && (n_phase != PH_START);
        o_res.acc        = n_acc;
        if (!n_dig) begin
            o_res.oct1 = 4'd5;
        end else if (n_neg) begin
            o_res.oct1 = (n_mag != 4'd0) ? 4'd0 : 4'd1;
        end else begin
            o_res.oct1 = (n_mag > 4'd9) ? 4'd10 : n_mag + 4'd1;
        end
    end

    // Return to start of name after the last character.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_acc   <= '0;
            r_mag   <= '0;
            r_neg   <= 1'b0;
            r_dig   <= 1'b0;
        end else if (i_take) begin
            if (i_last_char) begin
                r_phase <= PH_START;
                r_acc   <= '0;
                r_mag   <= '0;
                r_neg   <= 1'b0;
                r_dig   <= 1'b0;
            end else begin
                r_phase <= n_phase;
                r_acc   <= n_acc;
                r_mag   <= n_mag;
                r_neg   <= n_neg;
                r_dig   <= n_dig;
            end
        end
    end

endmodule

// ----- design/note_name_to_frequency.sv -----
// Top level of the note-name-to-frequency decoder.
// Depends on nnf_pkg and nnf_parse.
//
// Takes a note name one character per transaction (letter A-G in either case,
// optional sharp '#'/'s'/'S' or flat 'b'/'f'/'F', optional '-' and octave
// digits, octave 4 by default) and, on the transaction flagged last, returns
// the note number ((octave + 1) * 12 + semitone, A4 = 69) and the twelve-tone
// equal-tempered frequency (A4 = 440 Hz) in unsigned fixed point with
// FRAC_BITS fraction bits, rounded half up and saturated at 2^31 - 1. The
// octave clamps to -1..9. A bad first letter gives name_valid 0 with note and
// frequency 0; characters after the octave are ignored. One character is
// accepted every cycle while input ready is high. The accepting edge of a
// name's last character registers the parsed note, table index and octave
// shift in the middle stage; the output register then takes the 12-entry
// frequency table lookup and the rounding barrel shift and offers the result.
// The output register and the middle stage hold results while the sink
// stalls, and input ready falls only when both are full.
module note_name_to_frequency
    import nnf_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [7:0]               i_char_code,
    input  logic                     i_last_char,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [FREQ_W-1:0]        o_freq_fixed,
    output logic signed [NOTE_W-1:0] o_note_number,
    output logic                     o_name_valid
);

    localparam logic [5:0] SHIFT_BASE = 6'(36 - FRAC_BITS);

    t_parse_res w_res;
    logic       w_take;
    logic       w_mid_load;
    logic       w_out_load;

    // Middle stage: note number, table index and octave count.
    logic                     r_mid_vld;
    logic signed [NOTE_W-1:0] r_mid_note, n_mid_note;
    logic [3:0]               r_mid_idx, n_mid_idx;
    logic [3:0]               r_mid_q, n_mid_q;
    logic                     r_mid_nv;

    // Output stage.
    logic                     r_out_vld;
    logic [FREQ_W-1:0]        r_out_freq, n_out_freq;
    logic signed [NOTE_W-1:0] r_out_note;
    logic                     r_out_nv;

    logic [4:0]        w_t;
    logic [7:0]        w_oct12;
    logic [5:0]        w_shift;
    logic [PROD_W:0]   w_sum;
    logic [PROD_W:0]   w_scaled;

    assign w_out_load = r_mid_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_mid_vld || w_out_load;
    assign w_take     = i_in_valid && o_in_ready;
    assign w_mid_load = w_take && i_last_char;

    nnf_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (w_take),
        .i_char_code (i_char_code),
        .i_last_char (i_last_char),
        .o_res       (w_res)
    );

    // note + 3 = oct1 * 12 + (acc + 2); split it into octave count and index.
    always_comb begin
        w_oct12    = {1'b0, w_res.oct1, 3'b000} + {2'b00, w_res.oct1, 2'b00};
        n_mid_note = $signed({1'b0, w_oct12}) + $signed({4'b0000, w_res.acc}) -
                     9'sd1;
        w_t        = w_res.acc + 5'd2;
        if (w_t >= 5'd12) begin
            n_mid_idx = 4'(w_t - 5'd12);
            n_mid_q   = w_res.oct1 + 4'd1;
        end else begin
            n_mid_idx = w_t[3:0];
            n_mid_q   = w_res.oct1;
        end
    end

    // Scale the exact product down by 2^shift, add half for rounding, saturate.
    always_comb begin
        w_shift  = SHIFT_BASE - {2'b00, r_mid_q};
        w_sum    = {1'b0, note_prod(r_mid_idx)} + ((PROD_W+1)'(1) << (w_shift - 6'd1));
        w_scaled = w_sum >> w_shift;
        if (!r_mid_nv) begin
            n_out_freq = '0;
        end else if (|w_scaled[PROD_W:FREQ_W]) begin
            n_out_freq = '1;
        end else begin
            n_out_freq = w_scaled[FREQ_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_mid_load) begin
                r_mid_vld <= 1'b1;
            end else if (w_out_load) begin
                r_mid_vld <= 1'b0;
            end
            if (w_out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Hold payload while stalled; invalid names carry note 0.
    always_ff @(posedge i_clk) begin
        if (w_mid_load) begin
            r_mid_nv   <= w_res.name_valid;
            r_mid_note <= w_res.name_valid ? n_mid_note : '0;
            r_mid_idx  <= n_mid_idx;
            r_mid_q    <= n_mid_q;
        end
        if (w_out_load) begin
            r_out_freq <= n_out_freq;
            r_out_note <= r_mid_note;
            r_out_nv   <= r_mid_nv;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_freq_fixed  = r_out_freq;
    assign o_note_number = r_out_note;
    assign o_name_valid  = r_out_nv;

endmodule

// ----- test/nnf_checker.sv -----
// Scoreboard for note_name_to_frequency: watches the character and result channels,
// decodes each name on its own and compares every result field by field.
// Depends on nnf_pkg for the field widths and the parse phase type.
`timescale 1ns / 100ps

module nnf_checker
    import nnf_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic                     i_in_ready,
    input  logic [7:0]               i_char_code,
    input  logic                     i_last_char,
    input  logic                     i_out_valid,
    input  logic                     i_out_ready,
    input  logic [FREQ_W-1:0]        i_freq_fixed,
    input  logic signed [NOTE_W-1:0] i_note_number,
    input  logic                     i_name_valid,
    output int                       o_mismatches,
    output int                       o_outstanding
);

    localparam logic [7:0] CH_SHARP   = "#";
    localparam logic [7:0] CH_SHARP_L = "s";
    localparam logic [7:0] CH_SHARP_U = "S";
    localparam logic [7:0] CH_FLAT_B  = "b";
    localparam logic [7:0] CH_FLAT_L  = "f";
    localparam logic [7:0] CH_FLAT_U  = "F";
    localparam logic [7:0] CH_MINUS   = "-";
    localparam logic [7:0] CH_ZERO    = "0";
    localparam logic [7:0] CH_NINE    = "9";
    localparam logic [7:0] CH_UPPER_A = "A";
    localparam logic [7:0] CH_UPPER_G = "G";
    localparam logic [7:0] CH_LOWER_A = "a";
    localparam logic [7:0] CH_LOWER_Z = "z";
    localparam logic [7:0] CASE_GAP   = 8'd32;
    localparam int         OCT_SAT    = 10;
    localparam int         A4_NOTE    = 69;

    // semitone above C for the letters A..G
    localparam int LETTER_OFFSET [7] = '{9, 11, 0, 2, 4, 5, 7};

    // 2^(r/12) in Q2.30, rounded to nearest
    localparam longint unsigned SEMI_RATIO [12] = '{
        64'd1073741824, 64'd1137589835, 64'd1205234447, 64'd1276901417,
        64'd1352829926, 64'd1433273380, 64'd1518500250, 64'd1608794974,
        64'd1704458901, 64'd1805811301, 64'd1913190429, 64'd2026954652
    };

    typedef struct packed {
        logic [FREQ_W-1:0]        freq;
        logic signed [NOTE_W-1:0] note;
        logic                     valid;
    } t_note_result;

    t_note_result expected_notes [$];

    t_phase     phase;
    logic [4:0] semi_acc;
    logic [3:0] oct_mag;
    logic       oct_neg;
    logic       got_digit;

    function automatic bit is_digit(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    // Equal-tempered frequency of a note, rounded half up, saturated to the port width.
    function automatic logic [FREQ_W-1:0] tone_frequency(input int note);
        int                d;
        int                s;
        longint unsigned   prod;
        longint unsigned   f;
        d    = note - A4_NOTE + 72;
        s    = 36 - FRAC_BITS - d / 12;
        prod = 64'd440 * SEMI_RATIO[d % 12];
        f    = (prod + (64'd1 << (s - 1))) >> s;
        if (f > 64'h7FFF_FFFF) f = 64'h7FFF_FFFF;
        return f[FREQ_W-1:0];
    endfunction

    task automatic clear_name();
        phase     = PH_START;
        semi_acc  = '0;
        oct_mag   = '0;
        oct_neg   = 1'b0;
        got_digit = 1'b0;
    endtask

    task automatic take_digit(input logic [7:0] c);
        int m;
        m         = int'(oct_mag) * 10 + int'(c - CH_ZERO);
        oct_mag   = 4'((m > 9) ? OCT_SAT : m);
        got_digit = 1'b1;
        phase     = PH_DIGITS;
    endtask

    task automatic after_mark(input logic [7:0] c);
        if (c == CH_MINUS) begin
            oct_neg = 1'b1;
            phase   = PH_MINUS;
        end else if (is_digit(c)) begin
            take_digit(c);
        end else begin
            phase = PH_DONE;
        end
    endtask

    // Advance the parse by one character; on the last one queue the result.
    task automatic decode_char(input logic [7:0] c, input logic last);
        logic [7:0]   u;
        int           octave;
        int           note;
        t_note_result r;
        case (phase)
            PH_START: begin
                u = (c >= CH_LOWER_A && c <= CH_LOWER_Z) ? c - CASE_GAP : c;
                if (u >= CH_UPPER_A && u <= CH_UPPER_G) begin
                    semi_acc = 5'(LETTER_OFFSET[u - CH_UPPER_A] + 1);
                    phase    = PH_LETTER;
                end else begin
                    phase = PH_INVALID;
                end
            end
            PH_LETTER: begin
                if (c == CH_SHARP || c == CH_SHARP_L || c == CH_SHARP_U) begin
                    semi_acc = semi_acc + 5'd1;
                    phase    = PH_ACC;
                end else if (c == CH_FLAT_B || c == CH_FLAT_L || c == CH_FLAT_U) begin
                    semi_acc = semi_acc - 5'd1;
                    phase    = PH_ACC;
                end else begin
                    after_mark(c);
                end
            end
            PH_ACC: after_mark(c);
            PH_MINUS, PH_DIGITS: begin
                if (is_digit(c)) take_digit(c);
                else phase = PH_DONE;
            end
            default: ;
        endcase
        if (!last) return;

        if (phase == PH_START || phase == PH_INVALID) begin
            r = '0;
        end else begin
            if (!got_digit) octave = 4;
            else if (oct_neg) octave = (oct_mag > 0) ? -1 : 0;
            else octave = (oct_mag > 9) ? 9 : int'(oct_mag);
            note    = (octave + 1) * 12 + int'(semi_acc) - 1;
            r.freq  = tone_frequency(note);
            r.note  = NOTE_W'(note);
            r.valid = 1'b1;
        end
        expected_notes = {expected_notes, r};
        clear_name();
    endtask

    always @(posedge i_clk) begin
        t_note_result want;
        if (!i_rst_n) begin
            clear_name();
            expected_notes.delete();
            o_mismatches = 0;
        end else begin
            // an item accepted now cannot leave in the same cycle: check results first
            if (i_out_valid && i_out_ready) begin
                if (expected_notes.size() == 0) begin
                    $error("unexpected result: freq_fixed %0d note_number %0d name_valid %0d",
                           i_freq_fixed, i_note_number, i_name_valid);
                    o_mismatches++;
                end else begin
                    want = expected_notes.pop_front();
                    if (i_freq_fixed !== want.freq) begin
                        $error("freq_fixed: expected %0d, got %0d", want.freq, i_freq_fixed);
                        o_mismatches++;
                    end
                    if (i_note_number !== want.note) begin
                        $error("note_number: expected %0d, got %0d",
                               $signed(want.note), i_note_number);
                        o_mismatches++;
                    end
                    if (i_name_valid !== want.valid) begin
                        $error("name_valid: expected %0d, got %0d", want.valid, i_name_valid);
                        o_mismatches++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) decode_char(i_char_code, i_last_char);
        end
        o_outstanding = expected_notes.size();
    end

endmodule

// ----- test/tb_note_name_to_frequency.sv -----
// Testbench top for note_name_to_frequency: drives note names one character per
// transaction, stalls the result side at random and reports the verdict.
// Depends on nnf_pkg, note_name_to_frequency and nnf_checker.
`timescale 1ns / 100ps

module tb_note_name_to_frequency;
    import nnf_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 6;
    localparam int MAX_IDLE     = 11;
    localparam int RANDOM_CHARS = 1200;
    localparam int DRAIN_EVERY  = 400;
    localparam int TAIL_CYCLES  = 10;
    // ~1500 transactions in all; the run should end well under this limit
    localparam int CYCLE_LIMIT  = 400000;

    localparam string NOTE_LETTERS = "ABCDEFGabcdefg";
    localparam string NOTE_MARKS   = "#sSbfF";
    localparam string OCT_DIGITS   = "0123456789";

    // Hand-picked names: every letter in upper or lower case, every accidental mark,
    // lowest and highest notes, octave saturation both ways, minus zero,
    // minus with no digits, trailing junk, bad first characters.
    string directed_names [21] = '{
        "A", "a4", "B#9", "Cb-1", "cf-12", "DF5", "es0", "FS12", "g-", "G-0",
        "C-5x", "e4z9", "H4", "x", "7", "Ab3", "c#", "B99", "A4A4", "fb", "Gs-3"
    };

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic [7:0]               char_code;
    logic                     last_char;
    logic                     out_valid;
    logic                     out_ready;
    logic [FREQ_W-1:0]        freq_fixed;
    logic signed [NOTE_W-1:0] note_number;
    logic                     name_valid;

    int mismatches;
    int outstanding;
    int cycle_count = 0;
    bit idle_on     = 1'b1;   // cleared for stretches with back-to-back transactions

    note_name_to_frequency dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_char_code   (char_code),
        .i_last_char   (last_char),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_freq_fixed  (freq_fixed),
        .o_note_number (note_number),
        .o_name_valid  (name_valid)
    );

    nnf_checker checker_i (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_char_code   (char_code),
        .i_last_char   (last_char),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_freq_fixed  (freq_fixed),
        .i_note_number (note_number),
        .i_name_valid  (name_valid),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Watchdog: end the run if the pipeline hangs.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Offer one character: idle a random number of cycles, then hold valid and
    // payload until the transaction is accepted. Inputs change on the falling edge.
    task automatic send_char(input logic [7:0] c, input logic last);
        int gap;
        gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        repeat (gap) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid  <= 1'b1;
        char_code <= c;
        last_char <= last;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic send_chars(input logic [7:0] chars [$]);
        foreach (chars[i]) send_char(chars[i], i == chars.size() - 1);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
    endtask

    // Hold off the sender until every queued result has come out.
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
    endtask

    // Result side: stall a random number of cycles before taking each result.
    initial begin
        int stall;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            stall = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
            repeat (stall) begin
                @(negedge clk);
                out_ready <= 1'b0;
            end
            @(negedge clk);
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial begin
        logic [7:0] name [$];
        int         sent_chars;
        int         next_drain;
        int         n_junk;
        int         useful;

        in_valid  = 1'b0;
        char_code = '0;
        last_char = 1'b0;
        rst_n     = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part: run the first names back to back, then with idling.
        idle_on = 1'b0;
        foreach (directed_names[i]) begin
            if (i == 8) idle_on = 1'b1;
            send_text(directed_names[i]);
        end
        // extremes of the character code, alone and as ignored junk
        send_char(8'hFF, 1'b1);
        send_char(8'h00, 1'b1);
        send_chars('{"A", 8'h00, 8'hFF});
        drain_results();

        // Random part: mostly well-formed names with random content, the rest noise.
        sent_chars = 0;
        next_drain = DRAIN_EVERY;
        while (sent_chars < RANDOM_CHARS) begin
            if ($urandom_range(0, 39) == 0) idle_on = ~idle_on;
            name.delete();
            if ($urandom_range(0, 6) != 0) begin
                name = {name, NOTE_LETTERS[$urandom_range(0, NOTE_LETTERS.len() - 1)]};
                if ($urandom_range(0, 2) != 0)
                    name = {name, NOTE_MARKS[$urandom_range(0, NOTE_MARKS.len() - 1)]};
                if ($urandom_range(0, 3) == 0) name = {name, 8'("-")};
                repeat ($urandom_range(0, 3))
                    name = {name, OCT_DIGITS[$urandom_range(0, 9)]};
                useful = name.size();
                // drop a little junk after some names; it is not counted as useful
                n_junk = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
                repeat (n_junk) name = {name, 8'($urandom_range(0, 255))};
            end else begin
                repeat ($urandom_range(1, 5)) name = {name, 8'($urandom_range(0, 255))};
                useful = name.size();
            end
            send_chars(name);
            sent_chars += useful;
            if (sent_chars >= next_drain) begin
                drain_results();
                next_drain += DRAIN_EVERY;
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(negedge clk);

        if (mismatches == 0 && outstanding == 0) begin
            $display("tb: success");
        end else begin
            if (outstanding != 0) $error("%0d results never arrived", outstanding);
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- files.f -----
design/nnf_pkg.sv
design/nnf_parse.sv
design/note_name_to_frequency.sv
test/nnf_checker.sv
test/tb_note_name_to_frequency.sv
